// ----- design/tzo_pkg.sv -----
package tzo_pkg;

   localparam int unsigned ACC_W = 63;
   localparam int unsigned RSP_DATA_W = 80;

   localparam logic [ACC_W-1:0] ACC_MAX = '1;
   localparam logic [ACC_W-1:0] DIGIT_LIMIT = ACC_MAX / 10;
   localparam logic [3:0] DIGIT_REM = 4'(ACC_MAX % 10);
   localparam logic [ACC_W-1:0] HOUR_LIMIT = ACC_MAX / 3600;
   localparam logic [ACC_W-1:0] MINUTE_LIMIT = ACC_MAX / 60;
   localparam logic [ACC_W-1:0] HOUR_SECONDS = 63'd3600;
   localparam logic [ACC_W-1:0] MINUTE_SECONDS = 63'd60;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_LT = 8'h3C;
   localparam logic [7:0] CH_GT = 8'h3E;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   typedef enum logic [3:0] {
      PH_STD_START,
      PH_STD_Q,
      PH_STD_ALPHA,
      PH_SIGN,
      PH_H_FIRST,
      PH_H,
      PH_M_START,
      PH_M,
      PH_S_START,
      PH_S,
      PH_DST_START,
      PH_DST_Q,
      PH_DST_ALPHA,
      PH_IGNORE
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_NONE,
      ROLE_STD,
      ROLE_DST,
      ROLE_SYNTAX
   } role_type;

   typedef struct packed {
      role_type         role;
      logic [4:0]       name_pos;
      logic             done;
      logic             neg;
      logic             std_empty;
      logic             dst_empty;
   } meta_type;

   typedef struct packed {
      meta_type         meta;
      logic [ACC_W-1:0] hours;
      logic [ACC_W-1:0] minutes;
      logic [ACC_W-1:0] seconds;
   } step_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // Appends one decimal digit, saturating at the accumulator maximum.
   function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [3:0] d);
      logic [ACC_W-1:0] limit;
      limit = (d > DIGIT_REM) ? DIGIT_LIMIT - 63'd1 : DIGIT_LIMIT;
      if (acc > limit) begin
         return ACC_MAX;
      end
      return (acc << 3) + (acc << 1) + {59'd0, d};
   endfunction

endpackage

// ----- design/tzo_parser.sv -----
module tzo_parser #(
   parameter int NAME_CAP = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        ch,
   output tzo_pkg::step_type step
);
   import tzo_pkg::*;

   localparam int CW = $clog2(NAME_CAP);
   localparam logic [CW-1:0] CAP_LAST = CW'(NAME_CAP - 1);

   phase_type        phase_ff, phase_in;
   logic             neg_ff, neg_in;
   logic [ACC_W-1:0] hours_ff, hours_in;
   logic [ACC_W-1:0] minutes_ff, minutes_in;
   logic [ACC_W-1:0] seconds_ff, seconds_in;
   logic [CW-1:0]    std_count_ff, std_count_in;
   logic [CW-1:0]    dst_count_ff, dst_count_in;

   always_comb begin
      phase_type eff;
      logic      lt_c;
      logic      gt_c;
      logic      letter_c;
      logic      digit_c;
      logic      colon_c;
      logic      sign_c;
      phase_in = phase_ff;
      neg_in = neg_ff;
      hours_in = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      std_count_in = std_count_ff;
      dst_count_in = dst_count_ff;
      step = '0;
      step.meta.role = ROLE_NONE;
      lt_c = (ch == CH_LT);
      gt_c = (ch == CH_GT);
      letter_c = is_letter(ch);
      digit_c = is_digit(ch);
      colon_c = (ch == CH_COLON);
      sign_c = (ch == CH_PLUS) || (ch == CH_MINUS);
      eff = phase_ff;
      if (ch == CH_NUL) begin
         step.meta.done = 1'b1;
         step.meta.neg = neg_ff;
         step.meta.std_empty = (std_count_ff == '0);
         step.meta.dst_empty = (dst_count_ff == '0);
         step.hours = hours_ff;
         step.minutes = minutes_ff;
         step.seconds = seconds_ff;
         phase_in = PH_STD_START;
         neg_in = 1'b0;
         hours_in = '0;
         minutes_in = '0;
         seconds_in = '0;
         std_count_in = '0;
         dst_count_in = '0;
      end else begin
         // A character that a phase does not consume falls through to the next one.
         if (eff == PH_STD_START && !lt_c) begin
            eff = PH_STD_ALPHA;
         end
         if (eff == PH_STD_ALPHA && !letter_c) begin
            eff = PH_SIGN;
         end
         if (eff == PH_SIGN && !sign_c) begin
            eff = PH_H_FIRST;
         end
         if ((eff == PH_H_FIRST && !digit_c) || (eff == PH_H && !digit_c && !colon_c)) begin
            eff = PH_DST_START;
         end
         if ((eff == PH_M_START || eff == PH_M) && !digit_c && !colon_c) begin
            eff = PH_DST_START;
         end
         if ((eff == PH_S_START || eff == PH_S) && !digit_c) begin
            eff = PH_DST_START;
         end
         unique case (eff)
            PH_STD_START: begin
               step.meta.role = ROLE_SYNTAX;
               phase_in = PH_STD_Q;
            end
            PH_STD_Q: begin
               if (gt_c) begin
                  step.meta.role = ROLE_SYNTAX;
                  phase_in = PH_SIGN;
               end else if (std_count_ff < CAP_LAST) begin
                  step.meta.role = ROLE_STD;
                  step.meta.name_pos = 5'(std_count_ff);
                  std_count_in = std_count_ff + 1'b1;
               end
            end
            PH_STD_ALPHA: begin
               phase_in = PH_STD_ALPHA;
               if (std_count_ff < CAP_LAST) begin
                  step.meta.role = ROLE_STD;
                  step.meta.name_pos = 5'(std_count_ff);
                  std_count_in = std_count_ff + 1'b1;
               end
            end
            PH_SIGN: begin
               step.meta.role = ROLE_SYNTAX;
               phase_in = PH_H_FIRST;
               if (ch == CH_MINUS) begin
                  neg_in = 1'b1;
               end
            end
            PH_H_FIRST, PH_H: begin
               step.meta.role = ROLE_SYNTAX;
               if (digit_c) begin
                  hours_in = acc_digit(hours_ff, ch[3:0]);
                  phase_in = PH_H;
               end else begin
                  phase_in = PH_M_START;
               end
            end
            PH_M_START, PH_M: begin
               step.meta.role = ROLE_SYNTAX;
               if (digit_c) begin
                  minutes_in = acc_digit(minutes_ff, ch[3:0]);
                  phase_in = PH_M;
               end else begin
                  phase_in = PH_S_START;
               end
            end
            PH_S_START, PH_S: begin
               step.meta.role = ROLE_SYNTAX;
               seconds_in = acc_digit(seconds_ff, ch[3:0]);
               phase_in = PH_S;
            end
            PH_DST_START: begin
               if (lt_c) begin
                  step.meta.role = ROLE_SYNTAX;
                  phase_in = PH_DST_Q;
               end else if (letter_c) begin
                  phase_in = PH_DST_ALPHA;
                  if (dst_count_ff < CAP_LAST) begin
                     step.meta.role = ROLE_DST;
                     step.meta.name_pos = 5'(dst_count_ff);
                     dst_count_in = dst_count_ff + 1'b1;
                  end
               end else begin
                  phase_in = PH_IGNORE;
               end
            end
            PH_DST_Q: begin
               if (gt_c) begin
                  step.meta.role = ROLE_SYNTAX;
                  phase_in = PH_IGNORE;
               end else if (dst_count_ff < CAP_LAST) begin
                  step.meta.role = ROLE_DST;
                  step.meta.name_pos = 5'(dst_count_ff);
                  dst_count_in = dst_count_ff + 1'b1;
               end
            end
            PH_DST_ALPHA: begin
               if (!letter_c) begin
                  phase_in = PH_IGNORE;
               end else if (dst_count_ff < CAP_LAST) begin
                  step.meta.role = ROLE_DST;
                  step.meta.name_pos = 5'(dst_count_ff);
                  dst_count_in = dst_count_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_IGNORE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STD_START;
         neg_ff <= 1'b0;
         hours_ff <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
         std_count_ff <= '0;
         dst_count_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         neg_ff <= neg_in;
         hours_ff <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         std_count_ff <= std_count_in;
         dst_count_ff <= dst_count_in;
      end
   end

endmodule

// ----- design/tzo_offset_pipe.sv -----
module tzo_offset_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tzo_pkg::step_type in_step,
   output logic              out_valid,
   input  logic              out_ready,
   output tzo_pkg::meta_type out_meta,
   output logic [63:0]       out_offset
);
   import tzo_pkg::*;

   logic             v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic             rdy1, rdy2, rdy3, rdy4, rdy5;

   step_type         s1_ff;
   meta_type         m2_ff, m3_ff, m4_ff, m5_ff;
   logic [ACC_W-1:0] hp2_ff, mp2_ff, sec2_ff, sec3_ff, t3_ff, t4_ff;
   logic [63:0]      off5_ff;

   logic [ACC_W-1:0] hp_in, mp_in, t3_in, t4_in;
   logic [63:0]      sum3, sum4, off5_in;

   assign rdy5 = !v5_ff || out_ready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      hp_in = (s1_ff.hours > HOUR_LIMIT) ? ACC_MAX : s1_ff.hours * HOUR_SECONDS;
      mp_in = (s1_ff.minutes > MINUTE_LIMIT) ? ACC_MAX : s1_ff.minutes * MINUTE_SECONDS;
      sum3 = {1'b0, hp2_ff} + {1'b0, mp2_ff};
      t3_in = sum3[63] ? ACC_MAX : sum3[ACC_W-1:0];
      sum4 = {1'b0, t3_ff} + {1'b0, sec3_ff};
      t4_in = sum4[63] ? ACC_MAX : sum4[ACC_W-1:0];
      off5_in = m4_ff.neg ? 64'd0 - {1'b0, t4_ff} : {1'b0, t4_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_ff <= in_step;
      end
      if (rdy2 && v1_ff) begin
         m2_ff <= s1_ff.meta;
         hp2_ff <= hp_in;
         mp2_ff <= mp_in;
         sec2_ff <= s1_ff.seconds;
      end
      if (rdy3 && v2_ff) begin
         m3_ff <= m2_ff;
         t3_ff <= t3_in;
         sec3_ff <= sec2_ff;
      end
      if (rdy4 && v3_ff) begin
         m4_ff <= m3_ff;
         t4_ff <= t4_in;
      end
      if (rdy5 && v4_ff) begin
         m5_ff <= m4_ff;
         off5_ff <= off5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_meta = m5_ff;
   assign out_offset = off5_ff;

endmodule

// ----- design/tz_string_offset_parser_unit.sv -----
// POSIX TZ string offset parser.
// The req channel carries one character of a TZ string per transaction; a NUL
// character ends the string and returns the parser to its start state.
// The rsp channel returns exactly one transaction per character, in order:
// the character's role and its position in its zone name. On the NUL
// character rsp_tlast is high, and the transaction also carries the offset
// in seconds west of UTC (saturated, negated for a minus sign) and the flags
// that mark an empty standard or daylight name.
// One character is accepted in every cycle while req_tready is high. The
// parse step runs in the cycle of acceptance; the offset arithmetic (scaling,
// two saturating adds and the sign) takes four more register stages before
// the result is presented on rsp.
// Each stage holds its item while the next one is full, so a stalled
// receiver fills the five stages before req_tready falls.
// Reset clears the parse state and empties the pipeline.
module tz_string_offset_parser_unit #(
   parameter int NAME_CAP = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] ch
   input  logic [7:0]                         req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] role, [6:2] name_pos, [70:7] offset_seconds, [71] std_empty,
   // [72] dst_empty, [79:73] zero
   output logic [tzo_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);
   import tzo_pkg::*;

   step_type    step;
   meta_type    out_meta;
   logic [63:0] out_offset;
   logic        take;

   assign take = req_tvalid && req_tready;

   tzo_parser #(
      .NAME_CAP(NAME_CAP)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .take(take),
      .ch(req_tdata),
      .step(step)
   );

   tzo_offset_pipe u_pipe (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_step(step),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_meta(out_meta),
      .out_offset(out_offset)
   );

   assign rsp_tdata = {7'd0, out_meta.dst_empty, out_meta.std_empty, out_offset,
                       out_meta.name_pos, out_meta.role};
   assign rsp_tlast = out_meta.done;

endmodule

// ----- design/tzo_port_checker.sv -----
module tzo_port_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tzo_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import tzo_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_final_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[RSP_DATA_W-1:7] == '0)
      else $error("final fields set on a non-terminator transaction");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ROLE_NONE || rsp_tdata[1:0] == ROLE_SYNTAX)
      |-> rsp_tdata[6:2] == 5'd0)
      else $error("name position on a non-name character");

   a_term_role: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[1:0] == ROLE_NONE)
      else $error("terminator reported with a role");

endmodule

bind tz_string_offset_parser_unit tzo_port_checker u_port_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
